// ===== rtl/gbsa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gbsa_pkg
// shared types and codes for the group-by sum core
// ---------------------------------------------------------------------------
package gbsa_pkg;

    localparam int unsigned VAL_W     = 64;
    localparam int unsigned MAX_LANES = 8;
    localparam int unsigned IDX_W     = 10;

    typedef logic [2:0] status_t;
    localparam status_t ST_MERGED = 3'd0;
    localparam status_t ST_NEW    = 3'd1;
    localparam status_t ST_FULL   = 3'd2;
    localparam status_t ST_EMPTY  = 3'd3;
    localparam status_t ST_SUM    = 3'd4;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [0:0] CFG_NO_VALUE = 1'b0;
    localparam logic [0:0] CFG_COLUMNS  = 1'b1;

    localparam logic [VAL_W-1:0] NO_VALUE_RESET = '1;
    localparam logic [3:0]       COLUMNS_RESET  = 4'd8;

    typedef struct packed {
        logic op;
        logic [63:0] key_hash;
        logic [IDX_W-1:0] slot_index;
        logic [MAX_LANES-1:0][VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t status;
        logic [IDX_W-1:0] slot;
        logic [63:0] group_key;
        logic [2:0] column;
        logic [VAL_W-1:0] column_total;
        logic total_valid;
        logic last;
    } rsp_t;

    typedef struct packed {
        logic       had;
        logic       present;
        logic       create;
    } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/gbsa_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gbsa_req_if / gbsa_rsp_if / gbsa_cfg_if
// valid/ready channels of the group-by sum core
// ---------------------------------------------------------------------------
interface gbsa_req_if;
    logic valid;
    logic ready;
    gbsa_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbsa_rsp_if;
    logic valid;
    logic ready;
    gbsa_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbsa_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/gbsa_lane.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gbsa_lane
// one summed column: sum memory, valid flags, null-aware merge
// ---------------------------------------------------------------------------
module gbsa_lane #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic                        clk,
    input  wire logic [AW-1:0]               raddr,
    output logic [gbsa_pkg::VAL_W-1:0]       rsum,
    output logic                             rvalid,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire gbsa_pkg::lane_ctl_t         ctl,
    input  wire logic [gbsa_pkg::VAL_W-1:0]  old_sum,
    input  wire logic [gbsa_pkg::VAL_W-1:0]  value
);
    logic [gbsa_pkg::VAL_W-1:0] sum_mem [SLOTS];
    logic                       vld_mem [SLOTS];
    logic [gbsa_pkg::VAL_W-1:0] new_sum;
    logic                       new_vld;

    always_comb
    begin
        if (ctl.create)
        begin
            new_sum = ctl.present ? value : '0;
            new_vld = ctl.present;
        end
        else
        begin
            if (ctl.had && ctl.present)
                new_sum = old_sum + value;
            else if (ctl.present)
                new_sum = value;
            else if (!ctl.had)
                new_sum = '0;
            else
                new_sum = old_sum;
            new_vld = ctl.had || ctl.present;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sum_mem[waddr] <= new_sum;
            vld_mem[waddr] <= new_vld;
        end
        rsum   <= sum_mem[raddr];
        rvalid <= vld_mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/group_by_sum_aggregator_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// group_by_sum_aggregator_core
// hash group-by with per-column 64-bit sums
// ---------------------------------------------------------------------------
// After reset the block clears its used flags one slot at a time and holds
// req.ready low meanwhile. A row request probes the table linearly from the
// low hash bits, each probed slot taking a registered key/flag read, then a
// compare; a hit or a free slot is written by the column lanes in parallel
// (all SUM_LANES on a free slot, the configured columns on a hit) at the end
// of the compare cycle, and a full table gives its result once every slot
// has been probed. The next request can be taken in the cycle the result is
// offered. A readout request offers one column per cycle while the output is
// not stalled, and the next request can be taken in the cycle the last
// column is offered; an empty slot gives a single result. A staging register
// lets the next request start while a result still waits on the output;
// output stalls hold the block until the output register is free.
module group_by_sum_aggregator_core #(
    parameter int unsigned TABLE_SLOTS = 1024,
    parameter int unsigned SUM_LANES   = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gbsa_cfg_if.sink  cfg,
    gbsa_req_if.sink  req,
    gbsa_rsp_if.source rsp
);
    localparam int unsigned AW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned IW = gbsa_pkg::IDX_W;
    localparam int unsigned VW = gbsa_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_IDLE, S_PRD, S_PCMP, S_RRD, S_RWAIT, S_EMIT, S_OUT, S_CLR
    } state_t;

    state_t state_reg;
    gbsa_pkg::req_t req_reg;
    logic [VW-1:0] novalue_reg;
    logic [3:0] columns_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [CW-1:0] count_reg;
    logic [2:0] col_reg;
    logic used_mem [TABLE_SLOTS];
    logic used_rd_reg;
    logic [63:0] key_mem [TABLE_SLOTS];
    logic [63:0] key_rd_reg;
    logic out_valid_reg;
    gbsa_pkg::rsp_t out_reg;
    gbsa_pkg::rsp_t res_reg;

    logic [3:0] lanes;
    logic lane_we;
    logic create;
    logic [SUM_LANES-1:0][VW-1:0] lsum;
    logic [SUM_LANES-1:0] lvld;
    logic [VW-1:0] sel_sum;
    logic sel_vld;
    logic out_free;

    always_comb
    begin
        if (columns_reg == 4'd0)
            lanes = 4'd1;
        else if ({28'd0, columns_reg} > SUM_LANES)
            lanes = 4'(SUM_LANES);
        else
            lanes = columns_reg;
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign create    = !used_rd_reg;
    assign lane_we   = (state_reg == S_PCMP)
                       && (!used_rd_reg || key_rd_reg == req_reg.key_hash);

    genvar g;
    generate
        for (g = 0; g < SUM_LANES; g++)
        begin : g_lane
            gbsa_pkg::lane_ctl_t ctl;
            logic active;
            assign active      = (4'(g) < lanes);
            assign ctl.create  = create;
            assign ctl.had     = lvld[g];
            assign ctl.present = active && (req_reg.value[g] != novalue_reg);
            gbsa_lane #(.SLOTS(TABLE_SLOTS), .AW(AW)) u_lane (
                .clk    (clk),
                .raddr  (addr_reg),
                .rsum   (lsum[g]),
                .rvalid (lvld[g]),
                .we     (lane_we && (active || create)),
                .waddr  (addr_reg),
                .ctl    (ctl),
                .old_sum(lsum[g]),
                .value  (req_reg.value[g])
            );
        end
    endgenerate

    always_comb
    begin
        sel_sum = '0;
        sel_vld = 1'b0;
        for (int j = 0; j < SUM_LANES; j++)
        begin
            if (col_reg == 3'(j))
            begin
                sel_sum = lsum[j];
                sel_vld = lvld[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PCMP && !used_rd_reg)
            key_mem[addr_reg] <= req_reg.key_hash;
        key_rd_reg <= key_mem[addr_reg];
        if (state_reg == S_CLR)
            used_mem[clr_addr_reg] <= 1'b0;
        else if (state_reg == S_PCMP && !used_rd_reg)
            used_mem[addr_reg] <= 1'b1;
        used_rd_reg <= used_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            novalue_reg   <= gbsa_pkg::NO_VALUE_RESET;
            columns_reg   <= gbsa_pkg::COLUMNS_RESET;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            col_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == gbsa_pkg::CFG_NO_VALUE)
                    novalue_reg <= cfg.wdata;
                else
                    columns_reg <= cfg.wdata[3:0];
            end
            if ((state_reg == S_OUT || state_reg == S_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        req_reg   <= req.data;
                        count_reg <= '0;
                        col_reg   <= '0;
                        if (req.data.op == gbsa_pkg::OP_ACC)
                        begin
                            addr_reg  <= req.data.key_hash[AW-1:0];
                            state_reg <= S_PRD;
                        end
                        else if ({{(32-IW){1'b0}}, req.data.slot_index} < TABLE_SLOTS)
                        begin
                            addr_reg  <= AW'(req.data.slot_index);
                            state_reg <= S_RRD;
                        end
                        else
                        begin
                            res_reg   <= '{gbsa_pkg::ST_EMPTY, req.data.slot_index,
                                           64'd0, 3'd0, '0, 1'b0, 1'b1};
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_PRD:
                    state_reg <= S_PCMP;
                S_PCMP:
                begin
                    if (!used_rd_reg)
                    begin
                        res_reg   <= '{gbsa_pkg::ST_NEW, IW'(addr_reg),
                                       req_reg.key_hash, 3'd0, '0, 1'b0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else if (key_rd_reg == req_reg.key_hash)
                    begin
                        res_reg   <= '{gbsa_pkg::ST_MERGED, IW'(addr_reg),
                                       req_reg.key_hash, 3'd0, '0, 1'b0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else if (count_reg == CW'(TABLE_SLOTS - 1))
                    begin
                        res_reg   <= '{gbsa_pkg::ST_FULL, '0,
                                       req_reg.key_hash, 3'd0, '0, 1'b0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        addr_reg  <= (addr_reg == AW'(TABLE_SLOTS - 1)) ? '0
                                     : addr_reg + 1'b1;
                        state_reg <= S_PRD;
                    end
                end
                S_RRD:
                    state_reg <= S_RWAIT;
                S_RWAIT:
                begin
                    if (!used_rd_reg)
                    begin
                        res_reg   <= '{gbsa_pkg::ST_EMPTY, req_reg.slot_index,
                                       64'd0, 3'd0, '0, 1'b0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{gbsa_pkg::ST_SUM, req_reg.slot_index, key_rd_reg,
                                     col_reg, sel_sum, sel_vld,
                                     ({1'b0, col_reg} + 4'd1 == lanes)};
                        if ({1'b0, col_reg} + 4'd1 == lanes)
                            state_reg <= S_IDLE;
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_CLR:
                begin
                    if (clr_addr_reg == AW'(TABLE_SLOTS - 1))
                        state_reg <= S_IDLE;
                    else
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request taken while busy");
    a_lane_write_probe: assert property (@(posedge clk) disable iff (!rst_n)
        lane_we |=> state_reg == S_OUT)
        else $error("lane write outside a probe hit");
`endif
endmodule
`default_nettype wire
